// ===== hw/rtl/vlt_pkg.sv =====
// Shared types, codes and sizes for the versioned lock table unit.
package vlt_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VER_W = 30;
  localparam int unsigned TXN_W = 64;

  typedef enum logic [1:0] {
    FUNC_LOCK   = 2'd0,
    FUNC_CHECK  = 2'd1,
    FUNC_UNLOCK = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_HELD      = 3'd1,
    RSN_STALE     = 3'd2,
    RSN_NOT_FOUND = 3'd3,
    RSN_FUTURE    = 3'd4,
    RSN_UNLOCKED  = 3'd5,
    RSN_FULL      = 3'd6,
    RSN_SPARE     = 3'd7
  } reason_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic             locked;
    logic [TXN_W-1:0] owner;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    func_e            func;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic [TXN_W-1:0] txn;
    logic [VER_W-1:0] owner_version;
  } req_t;

  typedef struct packed {
    logic    answer;
    reason_e reason;
    logic    wr_en;
    entry_t  wr_entry;
  } eval_t;

endpackage

// ===== hw/rtl/vlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== hw/rtl/vlt_eval.sv =====
// Request decision: answer, reason and entry write-back for one located entry.
module vlt_eval (
  input  vlt_pkg::req_t   req_i,
  input  logic            found_i,
  input  logic            full_i,
  input  vlt_pkg::entry_t entry_i,
  output vlt_pkg::eval_t  eval_o
);

  vlt_pkg::entry_t claim;
  vlt_pkg::entry_t unlocked;

  always_comb begin
    claim.key     = req_i.key;
    claim.version = req_i.version;
    claim.locked  = 1'b1;
    claim.owner   = req_i.txn;

    unlocked        = entry_i;
    unlocked.locked = 1'b0;

    eval_o.answer   = 1'b0;
    eval_o.reason   = vlt_pkg::RSN_OK;
    eval_o.wr_en    = 1'b0;
    eval_o.wr_entry = claim;

    unique case (req_i.func)
      vlt_pkg::FUNC_LOCK: begin
        if (!found_i) begin
          if (full_i) begin
            eval_o.reason = vlt_pkg::RSN_FULL;
          end else begin
            eval_o.answer = 1'b1;
            eval_o.wr_en  = 1'b1;
          end
        end else if (entry_i.locked) begin
          if (entry_i.version >= req_i.version) begin
            eval_o.reason = vlt_pkg::RSN_HELD;
          end else if (req_i.version < req_i.owner_version) begin
            eval_o.reason = vlt_pkg::RSN_STALE;
          end else begin
            eval_o.answer = 1'b1;
            eval_o.wr_en  = 1'b1;
          end
        end else begin
          if (entry_i.version > req_i.version) begin
            eval_o.reason = vlt_pkg::RSN_STALE;
          end else if (entry_i.version == req_i.version &&
                       req_i.version < req_i.owner_version) begin
            eval_o.reason = vlt_pkg::RSN_STALE;
          end else begin
            eval_o.answer = 1'b1;
            eval_o.wr_en  = 1'b1;
          end
        end
      end
      vlt_pkg::FUNC_CHECK: begin
        if (!found_i) begin
          eval_o.reason = vlt_pkg::RSN_NOT_FOUND;
        end else if (entry_i.locked) begin
          if (entry_i.owner != req_i.txn) begin
            eval_o.answer = 1'b1;
            eval_o.reason = vlt_pkg::RSN_HELD;
          end
        end else if (entry_i.version > req_i.version) begin
          eval_o.answer = 1'b1;
          eval_o.reason = vlt_pkg::RSN_STALE;
        end
      end
      vlt_pkg::FUNC_UNLOCK: begin
        eval_o.wr_entry = unlocked;
        if (!found_i) begin
          eval_o.reason = vlt_pkg::RSN_NOT_FOUND;
        end else if (!entry_i.locked) begin
          eval_o.reason = vlt_pkg::RSN_UNLOCKED;
        end else if (entry_i.version > req_i.version) begin
          eval_o.reason = vlt_pkg::RSN_STALE;
        end else if (entry_i.version < req_i.version) begin
          eval_o.reason = vlt_pkg::RSN_FUTURE;
        end else begin
          eval_o.answer = 1'b1;
          eval_o.wr_en  = 1'b1;
        end
      end
      default: begin
        // Unused request kind: change nothing, answer zero.
        eval_o.answer = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/versioned_lock_table_unit.sv =====
// Versioned lock table unit: top level with lookup sequencer and entry RAM.
// Each request scans the occupied entries (0..1024) from slot 0 and stops at the first key match.
// A new request is taken only once the previous one is done; the RAM read scan reads one entry per cycle.
// busy stays high from acceptance until the result strobe; results cannot be stalled.
// Reset empties the table at once (fill count cleared); the RAM is never swept.

module versioned_lock_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] object_key_i,
  input  logic [29:0] version_i,
  input  logic [63:0] txn_id_i,
  input  logic [29:0] owner_version_i,
  output logic        done_o,
  output logic        answer_o,
  output logic [2:0]  reason_o
);

  // Entries are never freed and inserts take the lowest free slot, so the
  // occupied slots are always 0 .. fill count - 1. Tracking the fill count
  // replaces a valid bit per entry.

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [vlt_pkg::CNT_W-1:0]  count_q, count_d;
  logic [vlt_pkg::CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic [vlt_pkg::ADDR_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [vlt_pkg::ADDR_W-1:0] slot_q, slot_d;
  logic                       pend_q, pend_d;
  logic                       found_q, found_d;
  logic                       done_q, done_d;
  logic                       answer_q, answer_d;
  logic [2:0]                 reason_q, reason_d;

  vlt_pkg::req_t   req_q, req_d;
  vlt_pkg::entry_t ent_q, ent_d;
  vlt_pkg::entry_t rd_entry;
  vlt_pkg::eval_t  eval;

  logic [vlt_pkg::ENTRY_W-1:0] rd_data;
  logic                        rd_en;
  logic                        wr_en;
  logic [vlt_pkg::ADDR_W-1:0]  wr_addr;
  logic                        accept;
  logic                        hit;
  logic                        scan_end;
  logic                        full;

  assign accept   = start && (state_q == S_IDLE);
  assign rd_entry = vlt_pkg::entry_t'(rd_data);
  // Data from the previous cycle's read is compared against the request key.
  assign hit      = pend_q && (rd_entry.key == req_q.key);
  assign scan_end = (scan_idx_q == count_q);
  assign full     = (count_q == vlt_pkg::CNT_W'(vlt_pkg::TABLE_ENTRIES));

  // Issue one read per cycle while unread occupied slots remain and no hit is seen.
  assign rd_en   = (state_q == S_SCAN) && !scan_end && !hit;
  assign wr_en   = (state_q == S_EXEC) && eval.wr_en;
  assign wr_addr = found_q ? slot_q : count_q[vlt_pkg::ADDR_W-1:0];

  vlt_ram #(
    .WIDTH(vlt_pkg::ENTRY_W),
    .DEPTH(vlt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(eval.wr_entry),
    .rd_en_i  (rd_en),
    .rd_addr_i(scan_idx_q[vlt_pkg::ADDR_W-1:0]),
    .rd_data_o(rd_data)
  );

  vlt_eval u_eval (
    .req_i  (req_q),
    .found_i(found_q),
    .full_i (full),
    .entry_i(ent_q),
    .eval_o (eval)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    cmp_idx_d  = cmp_idx_q;
    slot_d     = slot_q;
    pend_d     = pend_q;
    found_d    = found_q;
    req_d      = req_q;
    ent_d      = ent_q;
    done_d     = 1'b0;
    answer_d   = answer_q;
    reason_d   = reason_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d.func          = vlt_pkg::func_e'(func_i);
          req_d.key           = object_key_i;
          req_d.version       = version_i;
          req_d.txn           = txn_id_i;
          req_d.owner_version = owner_version_i;
          scan_idx_d          = '0;
          pend_d              = 1'b0;
          found_d             = 1'b0;
          state_d             = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Lowest matching slot wins; capture its contents.
          found_d = 1'b1;
          slot_d  = cmp_idx_q;
          ent_d   = rd_entry;
          pend_d  = 1'b0;
          state_d = S_EXEC;
        end else if (scan_end) begin
          // Last compare missed or the table is empty: key absent.
          pend_d  = 1'b0;
          state_d = S_EXEC;
        end else begin
          pend_d     = 1'b1;
          cmp_idx_d  = scan_idx_q[vlt_pkg::ADDR_W-1:0];
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      S_EXEC: begin
        // Write back, grow the table on insert, and present the result.
        if (eval.wr_en && !found_q) begin
          count_d = count_q + 1'b1;
        end
        done_d   = 1'b1;
        answer_d = eval.answer;
        reason_d = eval.reason;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      pend_q     <= pend_d;
      found_q    <= found_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    req_q     <= req_d;
    ent_q     <= ent_d;
    answer_q  <= answer_d;
    reason_q  <= reason_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign answer_o = answer_q;
  assign reason_o = reason_q;

endmodule

// ===== tb/versioned_lock_table_unit_test.sv =====
// Self-checking testbench for the versioned lock table unit: directed and random runs.
`timescale 1ns / 1ps

module versioned_lock_table_unit_test;
  import vlt_pkg::*;

  // One reply as the block reports it.
  typedef struct packed {
    logic    answer;
    reason_e reason;
  } lock_reply_t;

  localparam int unsigned KEY_POOL = 24;
  localparam int unsigned TXN_POOL = 4;
  localparam logic [TXN_W-1:0] TXN_A = 64'h0123_4567_89AB_CDEF;
  localparam logic [TXN_W-1:0] TXN_B = 64'hFEDC_BA98_7654_3210;
  localparam logic [VER_W-1:0] VER_MAX = {VER_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  // Longest accept-to-strobe time: full scan of the table plus pipeline.
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES + 80;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       func_i;
  logic [KEY_W-1:0] object_key_i;
  logic [VER_W-1:0] version_i;
  logic [TXN_W-1:0] txn_id_i;
  logic [VER_W-1:0] owner_version_i;
  logic             done_o;
  logic             answer_o;
  logic [2:0]       reason_o;

  // Shadow copy of the lock table, updated at every accepted transaction.
  bit               shadow_valid   [TABLE_ENTRIES];
  logic [KEY_W-1:0] shadow_key     [TABLE_ENTRIES];
  logic [VER_W-1:0] shadow_version [TABLE_ENTRIES];
  logic             shadow_locked  [TABLE_ENTRIES];
  logic [TXN_W-1:0] shadow_owner   [TABLE_ENTRIES];
  int unsigned      shadow_fill;

  lock_reply_t      pending_replies[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [TXN_W-1:0] txn_pool [TXN_POOL];

  int unsigned idle_pct;
  int unsigned requests_sent;
  int unsigned replies_checked;
  int unsigned mismatch_count;
  int unsigned reason_count [8];

  versioned_lock_table_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .object_key_i    (object_key_i),
    .version_i       (version_i),
    .txn_id_i        (txn_id_i),
    .owner_version_i (owner_version_i),
    .done_o          (done_o),
    .answer_o        (answer_o),
    .reason_o        (reason_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Lowest valid slot that holds the key, or -1.
  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the reply it must produce.
  function automatic lock_reply_t apply_request(req_t rq);
    lock_reply_t rep;
    int          slot;
    bit          grant;
    rep.answer = 1'b0;
    rep.reason = RSN_OK;
    grant      = 1'b0;
    slot       = find_entry(rq.key);
    case (rq.func)
      FUNC_LOCK: begin
        if (slot < 0) begin
          // Insert into the lowest free slot, refuse when the table is full.
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!shadow_valid[i]) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) rep.reason = RSN_FULL;
          else begin
            grant = 1'b1;
            shadow_fill++;
          end
        end else if (shadow_locked[slot]) begin
          if (shadow_version[slot] >= rq.version) rep.reason = RSN_HELD;
          else if (rq.version < rq.owner_version) rep.reason = RSN_STALE;
          else grant = 1'b1;
        end else begin
          if (shadow_version[slot] > rq.version) rep.reason = RSN_STALE;
          else if (shadow_version[slot] == rq.version && rq.version < rq.owner_version)
            rep.reason = RSN_STALE;
          else grant = 1'b1;
        end
        if (grant) begin
          shadow_valid[slot]   = 1'b1;
          shadow_key[slot]     = rq.key;
          shadow_version[slot] = rq.version;
          shadow_locked[slot]  = 1'b1;
          shadow_owner[slot]   = rq.txn;
          rep.answer           = 1'b1;
        end
      end
      FUNC_CHECK: begin
        if (slot < 0) rep.reason = RSN_NOT_FOUND;
        else if (shadow_locked[slot]) begin
          if (shadow_owner[slot] != rq.txn) begin
            rep.answer = 1'b1;
            rep.reason = RSN_HELD;
          end
        end else if (shadow_version[slot] > rq.version) begin
          rep.answer = 1'b1;
          rep.reason = RSN_STALE;
        end
      end
      FUNC_UNLOCK: begin
        if (slot < 0) rep.reason = RSN_NOT_FOUND;
        else if (!shadow_locked[slot]) rep.reason = RSN_UNLOCKED;
        else if (shadow_version[slot] > rq.version) rep.reason = RSN_STALE;
        else if (shadow_version[slot] < rq.version) rep.reason = RSN_FUTURE;
        else begin
          shadow_locked[slot] = 1'b0;
          rep.answer          = 1'b1;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Random request, biased toward keys in the table and versions near the stored one.
  function automatic req_t make_random_request();
    req_t rq;
    int   slot;
    int   pick;
    pick = $urandom_range(99);
    rq.func = (pick < 40) ? FUNC_LOCK : (pick < 65) ? FUNC_CHECK :
              (pick < 95) ? FUNC_UNLOCK : FUNC_NONE;
    rq.key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
    rq.version = VER_W'($urandom());
    rq.txn = {$urandom(), $urandom()};
    slot = find_entry(rq.key);
    if (slot >= 0) begin
      case ($urandom_range(5))
        0, 1: rq.version = shadow_version[slot];
        2:    rq.version = shadow_version[slot] + 1'b1;
        3:    rq.version = shadow_version[slot] - 1'b1;
        4:    rq.version = shadow_version[slot] + VER_W'($urandom_range(2, 9));
        default: ;
      endcase
      if ($urandom_range(2) != 0) rq.txn = shadow_owner[slot];
    end else if ($urandom_range(1) == 0) begin
      rq.version = VER_W'($urandom_range(15));
    end
    if ($urandom_range(3) == 0) rq.txn = txn_pool[$urandom_range(TXN_POOL - 1)];
    case ($urandom_range(5))
      0, 1: rq.owner_version = rq.version;
      2:    rq.owner_version = rq.version + 1'b1;
      3:    rq.owner_version = rq.version - 1'b1;
      4:    rq.owner_version = '0;
      default: rq.owner_version = VER_W'($urandom());
    endcase
    return rq;
  endfunction

  // Drive one transaction at the falling edge, hold it until accepted, then predict.
  // Enter and leave at a falling edge.
  task automatic send_request(input func_e func, input logic [KEY_W-1:0] key,
                              input logic [VER_W-1:0] ver, input logic [TXN_W-1:0] txn,
                              input logic [VER_W-1:0] own);
    req_t rq;
    rq.func          = func;
    rq.key           = key;
    rq.version       = ver;
    rq.txn           = txn;
    rq.owner_version = own;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk_i);
    func_i          = func;
    object_key_i    = key;
    version_i       = ver;
    txn_id_i        = txn;
    owner_version_i = own;
    start           = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_replies.push_back(apply_request(rq));
    requests_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Compare every strobed reply with the oldest prediction.
  always @(posedge clk_i) begin
    lock_reply_t want;
    if (rst_ni && done_o === 1'b1) begin
      replies_checked++;
      reason_count[reason_o]++;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: expected none, actual answer %0b reason %0d",
                 $time, answer_o, reason_o);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (answer_o !== want.answer) begin
          $display("%0t: answer mismatch: expected %0b, actual %0b",
                   $time, want.answer, answer_o);
          mismatch_count++;
        end
        if (reason_o !== want.reason) begin
          $display("%0t: reason mismatch: expected %0d (%s), actual %0d",
                   $time, want.reason, want.reason.name(), reason_o);
          mismatch_count++;
        end
      end
    end
  end

  // Walk three keys through the lock, check and unlock rules, all but the full-table refusal, on a near-empty table.
  task automatic test_directed_cases();
    idle_pct = 0;
    send_request(FUNC_CHECK,  '0,      30'd5,   TXN_A, 30'd0);   // check, key absent
    send_request(FUNC_UNLOCK, KEY_MAX, 30'd5,   TXN_A, 30'd0);   // unlock, key absent
    send_request(FUNC_LOCK,   '0,      30'd5,   TXN_A, 30'd7);   // insert
    send_request(FUNC_CHECK,  '0,      30'd5,   TXN_A, 30'd0);   // locked by requester
    send_request(FUNC_CHECK,  '0,      30'd5,   TXN_B, 30'd0);   // locked by another
    send_request(FUNC_LOCK,   '0,      30'd5,   TXN_B, 30'd0);   // locked, same version
    send_request(FUNC_LOCK,   '0,      30'd9,   TXN_B, 30'd12);  // locked, behind owner node
    send_request(FUNC_LOCK,   '0,      30'd9,   TXN_B, 30'd9);   // locked, takeover
    send_request(FUNC_UNLOCK, '0,      30'd8,   TXN_B, 30'd0);   // unlock, stale
    send_request(FUNC_UNLOCK, '0,      30'd10,  TXN_B, 30'd0);   // unlock, future
    send_request(FUNC_UNLOCK, '0,      30'd9,   TXN_B, 30'd0);   // unlock, clears flag
    send_request(FUNC_UNLOCK, '0,      30'd9,   TXN_B, 30'd0);   // already unlocked
    send_request(FUNC_CHECK,  '0,      30'd8,   TXN_A, 30'd0);   // unlocked, stored newer
    send_request(FUNC_CHECK,  '0,      30'd9,   TXN_A, 30'd0);   // unlocked, up to date
    send_request(FUNC_LOCK,   '0,      30'd8,   TXN_A, 30'd0);   // unlocked, stored newer
    send_request(FUNC_LOCK,   '0,      30'd9,   TXN_A, 30'd10);  // unlocked, equal, behind
    send_request(FUNC_LOCK,   '0,      30'd9,   TXN_A, 30'd9);   // unlocked, equal, relock
    send_request(FUNC_NONE,   '0,      30'd9,   TXN_A, 30'd9);   // unused request kind
    send_request(FUNC_LOCK,   KEY_MAX, VER_MAX, '1,    VER_MAX); // all-ones fields
    send_request(FUNC_UNLOCK, KEY_MAX, VER_MAX, '1,    '0);
    send_request(FUNC_LOCK,   KEY_MAX, VER_MAX, '0,    '0);      // unlocked, equal, relock
    send_request(FUNC_CHECK,  KEY_MAX, '0,      '0,    '0);      // locked by requester
    send_request(FUNC_LOCK,   32'h8000_0000, '0, TXN_B, VER_MAX); // insert ignores owner node
    send_request(FUNC_LOCK,   KEY_MAX, VER_MAX, TXN_A, '0);      // locked, max version held
  endtask

  // Random traffic over a small key pool so the table stays short.
  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned count);
    req_t rq;
    idle_pct = gap_pct;
    repeat (count) begin
      rq = make_random_request();
      send_request(rq.func, rq.key, rq.version, rq.txn, rq.owner_version);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = FUNC_NONE;
    object_key_i    = '0;
    version_i       = '0;
    txn_id_i        = '0;
    owner_version_i = '0;
    idle_pct        = 0;
    shadow_fill     = 0;
    requests_sent   = 0;
    replies_checked = 0;
    mismatch_count  = 0;
    foreach (reason_count[i]) reason_count[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    foreach (txn_pool[i]) txn_pool[i] = {$urandom(), $urandom()};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    // Phases: no gaps, sparse sender, moderate sender, then no gaps again.
    test_random_traffic(0,  140);
    test_random_traffic(73, 150);
    test_random_traffic(26, 150);
    test_random_traffic(0,  120);

    // Drain outstanding replies, then watch for strays over one full scan.
    wait (pending_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d replies checked, table holds %0d of %0d entries",
             requests_sent, replies_checked, shadow_fill, TABLE_ENTRIES);
    $display("replies by reason: ok %0d held %0d stale %0d not-found %0d future %0d %s %0d %s %0d",
             reason_count[RSN_OK], reason_count[RSN_HELD], reason_count[RSN_STALE],
             reason_count[RSN_NOT_FOUND], reason_count[RSN_FUTURE],
             "unlocked", reason_count[RSN_UNLOCKED], "full", reason_count[RSN_FULL]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop: several times the slowest legal run, full-table scans included.
  initial begin
    #40_000_000;
    $display("timeout: %0d replies still pending", pending_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
